// ===== hdl/rckt_pkg.sv =====
package rckt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_DIM       = 1024;
  localparam int DIM_W         = 11;
  localparam int COORD_W       = 10;
  localparam int SLOT_W        = 4;
  localparam int COLOR_W       = 24;
  localparam int CALC_W        = 13;

  typedef enum logic [2:0] {
    REG_ORIENTATION  = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4,
    REG_GRID_WIDTH   = 3'd5,
    REG_GRID_HEIGHT  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [SLOT_W-1:0]  entry_slot;
    logic               entry_enable;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [SLOT_W-1:0]  tile_code;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
    logic               valid;
  } key_wr_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] code;
  } key_match_t;

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  function automatic logic [DIM_W-1:0] image_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM_V) begin
      r = MAX_DIM_V;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] grid_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM_V) ? MAX_DIM_V : v;
  endfunction

endpackage

// ===== hdl/rotated_color_key_tile_mapper_core.sv =====
// Results are registered in the output buffer before they are offered on out_valid.
// Throughput: one item per cycle while in_ready is high; counters, rotation adders
// and the 16-entry parallel color compare all sit between input and output register.
// A two-deep output buffer holds one extra result; input stalls while both are full.
// Reset (rst_n low, synchronous): counters, table valid bits and output buffer
// cleared, configuration registers back to their defaults.
module rotated_color_key_tile_mapper_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rckt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rckt_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int DW = rckt_pkg::DIM_W;
  localparam int CW = rckt_pkg::COORD_W;
  localparam int XW = rckt_pkg::CALC_W;

  // configuration
  logic [1:0]    orientation_r;
  logic [DW-1:0] image_width_r, image_height_r;
  logic [CW-1:0] origin_x_r, origin_y_r;
  logic [DW-1:0] grid_width_r, grid_height_r;
  logic          cfg_wr;
  rckt_pkg::cfg_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rckt_pkg::cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orientation_r  <= 2'd1;
      image_width_r  <= DW'(16);
      image_height_r <= DW'(16);
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      grid_width_r   <= DW'(64);
      grid_height_r  <= DW'(64);
    end else if (cfg_wr) begin
      case (cfg_idx)
        rckt_pkg::REG_ORIENTATION:  orientation_r  <= pwdata[1:0];
        rckt_pkg::REG_IMAGE_WIDTH:  image_width_r  <= pwdata[DW-1:0];
        rckt_pkg::REG_IMAGE_HEIGHT: image_height_r <= pwdata[DW-1:0];
        rckt_pkg::REG_ORIGIN_X:     origin_x_r     <= pwdata[CW-1:0];
        rckt_pkg::REG_ORIGIN_Y:     origin_y_r     <= pwdata[CW-1:0];
        rckt_pkg::REG_GRID_WIDTH:   grid_width_r   <= pwdata[DW-1:0];
        rckt_pkg::REG_GRID_HEIGHT:  grid_height_r  <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rckt_pkg::REG_ORIENTATION:  prdata = {30'd0, orientation_r};
      rckt_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-DW){1'b0}}, image_width_r};
      rckt_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-DW){1'b0}}, image_height_r};
      rckt_pkg::REG_ORIGIN_X:     prdata = {{(32-CW){1'b0}}, origin_x_r};
      rckt_pkg::REG_ORIGIN_Y:     prdata = {{(32-CW){1'b0}}, origin_y_r};
      rckt_pkg::REG_GRID_WIDTH:   prdata = {{(32-DW){1'b0}}, grid_width_r};
      rckt_pkg::REG_GRID_HEIGHT:  prdata = {{(32-DW){1'b0}}, grid_height_r};
      default:                    prdata = '0;
    endcase
  end

  // input side
  logic in_fire, pixel_fire;
  logic skid_valid_r;

  assign in_ready   = !skid_valid_r;
  assign in_fire    = in_valid && in_ready;
  assign pixel_fire = in_fire && (in_data.mode == rckt_pkg::MODE_PIXEL);

  rckt_pkg::key_wr_t    key_wr;
  rckt_pkg::key_match_t key_match;
  logic [rckt_pkg::COLOR_W-1:0] pix_color;

  assign pix_color    = {in_data.red, in_data.green, in_data.blue};
  assign key_wr.en    = in_fire && (in_data.mode == rckt_pkg::MODE_LOAD);
  assign key_wr.slot  = in_data.entry_slot;
  assign key_wr.color = pix_color;
  assign key_wr.valid = in_data.entry_enable;

  rckt_key_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (key_wr),
    .color (pix_color),
    .match (key_match)
  );

  // raster counters
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [DW-1:0] w_eff, h_eff, col_inc, row_inc;

  assign w_eff   = rckt_pkg::image_dim(image_width_r);
  assign h_eff   = rckt_pkg::image_dim(image_height_r);
  assign col_inc = {1'b0, col_r} + DW'(1);
  assign row_inc = {1'b0, row_r} + DW'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (pixel_fire) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[CW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // rotation and grid placement, signed so an out-of-image position goes negative
  logic signed [XW-1:0] sx, sy, sw, sh, ox, oy, tx, ty, gw, gh;
  logic in_grid;

  assign sx = $signed({{(XW-CW){1'b0}}, col_r});
  assign sy = $signed({{(XW-CW){1'b0}}, row_r});
  assign sw = $signed({{(XW-DW){1'b0}}, w_eff});
  assign sh = $signed({{(XW-DW){1'b0}}, h_eff});
  assign gw = $signed({{(XW-DW){1'b0}}, rckt_pkg::grid_dim(grid_width_r)});
  assign gh = $signed({{(XW-DW){1'b0}}, rckt_pkg::grid_dim(grid_height_r)});

  always_comb begin
    case (rckt_pkg::rot_t'(orientation_r))
      rckt_pkg::ROT_90: begin
        ox = sh - XW'(1) - sy;
        oy = sx;
      end
      rckt_pkg::ROT_180: begin
        ox = sw - XW'(1) - sx;
        oy = sh - XW'(1) - sy;
      end
      rckt_pkg::ROT_270: begin
        ox = sy;
        oy = sw - XW'(1) - sx;
      end
      default: begin
        ox = sx;
        oy = sy;
      end
    endcase
  end

  assign tx = ox + $signed({{(XW-CW){1'b0}}, origin_x_r});
  assign ty = oy + $signed({{(XW-CW){1'b0}}, origin_y_r});
  assign in_grid = !tx[XW-1] && !ty[XW-1] && (tx < gw) && (ty < gh);

  logic res_valid;
  rckt_pkg::out_item_t res;

  assign res_valid     = pixel_fire && (in_data.alpha != 8'd0) && in_grid && key_match.hit;
  assign res.tile_x    = tx[CW-1:0];
  assign res.tile_y    = ty[CW-1:0];
  assign res.tile_code = key_match.code;

  // output register plus skid entry
  logic out_valid_r, pop;
  rckt_pkg::out_item_t out_data_r, skid_data_r;

  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || pop) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

endmodule

// ===== hdl/rckt_key_table.sv =====
module rckt_key_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rckt_pkg::key_wr_t             wr,
  input  logic [rckt_pkg::COLOR_W-1:0]  color,
  output rckt_pkg::key_match_t          match
);

  logic [rckt_pkg::COLOR_W-1:0] key_colors_r [rckt_pkg::TABLE_ENTRIES];
  logic [rckt_pkg::TABLE_ENTRIES-1:0] key_valid_r;
  logic slot_in_range;

  assign slot_in_range = ({1'b0, wr.slot} < (rckt_pkg::SLOT_W+1)'(rckt_pkg::TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_valid_r <= '0;
      for (int i = 0; i < rckt_pkg::TABLE_ENTRIES; i++) begin
        key_colors_r[i] <= '0;
      end
    end else if (wr.en && slot_in_range) begin
      for (int i = 0; i < rckt_pkg::TABLE_ENTRIES; i++) begin
        if ({1'b0, wr.slot} == (rckt_pkg::SLOT_W+1)'(i)) begin
          key_colors_r[i] <= wr.color;
          key_valid_r[i]  <= wr.valid;
        end
      end
    end
  end

  // lowest matching entry wins: scan from the top down
  always_comb begin
    match = '0;
    for (int i = rckt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (key_valid_r[i] && key_colors_r[i] == color) begin
        match.hit  = 1'b1;
        match.code = rckt_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

// ===== test/tb_rotated_color_key_tile_mapper_core.sv =====
module tb_rotated_color_key_tile_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 180;

  // Tracks the tile writes the mapper should produce, in source order.
  class tile_scoreboard;
    rckt_pkg::rot_t      orient;
    logic [10:0]         img_w, img_h, grid_w, grid_h;
    logic [9:0]          org_x, org_y;
    int                  col, row;
    logic [23:0]         key_color [rckt_pkg::TABLE_ENTRIES];
    bit                  key_on [rckt_pkg::TABLE_ENTRIES];
    rckt_pkg::out_item_t tiles_due [$];
    int                  errors;

    function new();
      orient = rckt_pkg::ROT_90;
      img_w  = 11'd16;
      img_h  = 11'd16;
      org_x  = '0;
      org_y  = '0;
      grid_w = 11'd64;
      grid_h = 11'd64;
      col    = 0;
      row    = 0;
      errors = 0;
      for (int i = 0; i < rckt_pkg::TABLE_ENTRIES; i++) begin
        key_color[i] = '0;
        key_on[i]    = 1'b0;
      end
    endfunction

    function int limit_dim(logic [10:0] v);
      return (int'(v) > rckt_pkg::MAX_DIM) ? rckt_pkg::MAX_DIM : int'(v);
    endfunction

    function void set_reg(rckt_pkg::cfg_reg_t r, logic [31:0] v);
      case (r)
        rckt_pkg::REG_ORIENTATION:  orient = rckt_pkg::rot_t'(v[1:0]);
        rckt_pkg::REG_IMAGE_WIDTH:  img_w  = v[10:0];
        rckt_pkg::REG_IMAGE_HEIGHT: img_h  = v[10:0];
        rckt_pkg::REG_ORIGIN_X:     org_x  = v[9:0];
        rckt_pkg::REG_ORIGIN_Y:     org_y  = v[9:0];
        rckt_pkg::REG_GRID_WIDTH:   grid_w = v[10:0];
        rckt_pkg::REG_GRID_HEIGHT:  grid_h = v[10:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return tiles_due.size();
    endfunction

    function void note_input(rckt_pkg::in_item_t it);
      int                  w, h, x, y, ox, oy, tx, ty, hit;
      logic [23:0]         color;
      rckt_pkg::out_item_t tile;
      color = {it.red, it.green, it.blue};
      if (it.mode == rckt_pkg::MODE_LOAD) begin
        key_color[it.entry_slot] = color;
        key_on[it.entry_slot]    = it.entry_enable;
        return;
      end
      w = (img_w == '0) ? 1 : limit_dim(img_w);
      h = (img_h == '0) ? 1 : limit_dim(img_h);
      x = col;
      y = row;
      // column moves on every pixel, transparent ones included
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
      if (it.alpha == '0) return;
      case (orient)
        rckt_pkg::ROT_90:  begin ox = h - 1 - y; oy = x;         end
        rckt_pkg::ROT_180: begin ox = w - 1 - x; oy = h - 1 - y; end
        rckt_pkg::ROT_270: begin ox = y;         oy = w - 1 - x; end
        default:           begin ox = x;         oy = y;         end
      endcase
      tx = ox + int'(org_x);
      ty = oy + int'(org_y);
      if (tx < 0 || ty < 0) return;
      if (tx >= limit_dim(grid_w) || ty >= limit_dim(grid_h)) return;
      hit = -1;
      for (int i = rckt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
        if (key_on[i] && key_color[i] == color) hit = i;
      end
      if (hit < 0) return;
      tile.tile_x    = tx[9:0];
      tile.tile_y    = ty[9:0];
      tile.tile_code = hit[3:0];
      tiles_due.push_back(tile);
    endfunction

    function void check_result(rckt_pkg::out_item_t got);
      rckt_pkg::out_item_t want;
      if (tiles_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected tile write: x=%0d y=%0d code=%0d",
                   got.tile_x, got.tile_y, got.tile_code);
        return;
      end
      want = tiles_due.pop_front();
      if (got.tile_x !== want.tile_x || got.tile_y !== want.tile_y ||
          got.tile_code !== want.tile_code) begin
        errors++;
        if (errors <= 10)
          $display("tile mismatch: expected x=%0d y=%0d code=%0d, got x=%0d y=%0d code=%0d",
                   want.tile_x, want.tile_y, want.tile_code,
                   got.tile_x, got.tile_y, got.tile_code);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  rckt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  rckt_pkg::out_item_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [4:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  tile_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  rotated_color_key_tile_mapper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rotated_color_key_tile_mapper_core verification failed");
    $finish;
  end

  // result side: check at the edge, then pick next cycle's ready
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic rckt_pkg::in_item_t load_item(int slot, logic [23:0] color,
                                                   logic enable);
    rckt_pkg::in_item_t it;
    it.mode         = rckt_pkg::MODE_LOAD;
    {it.red, it.green, it.blue} = color;
    it.alpha        = 8'($urandom());
    it.entry_slot   = slot[3:0];
    it.entry_enable = enable;
    return it;
  endfunction

  function automatic rckt_pkg::in_item_t pixel_item(logic [23:0] color, logic [7:0] alpha);
    rckt_pkg::in_item_t it;
    it.mode         = rckt_pkg::MODE_PIXEL;
    {it.red, it.green, it.blue} = color;
    it.alpha        = alpha;
    it.entry_slot   = 4'($urandom());
    it.entry_enable = 1'($urandom());
    return it;
  endfunction

  task automatic send_item(input rckt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // hold input until every tile write is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rckt_pkg::cfg_reg_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
  endtask

  function automatic logic [31:0] pick_image_dim();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd1024;
      3:       return 32'h7FF;
      default: return 32'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'd1023;
      2:       return 32'($urandom_range(0, 1023));
      default: return 32'($urandom_range(0, 20));
    endcase
  endfunction

  function automatic logic [31:0] pick_grid_dim();
    case ($urandom_range(11))
      0:       return 32'd0;
      1:       return 32'h7FF;
      2:       return 32'd1024;
      3:       return 32'd1;
      default: return 32'($urandom_range(8, 64));
    endcase
  endfunction

  task automatic random_item();
    rckt_pkg::in_item_t it;
    logic [23:0]        color;
    logic [7:0]         alpha;
    if ($urandom_range(99) < 12) begin
      it = load_item($urandom_range(rckt_pkg::TABLE_ENTRIES - 1), 24'($urandom()),
                     ($urandom_range(3) != 0));
    end else begin
      // mostly table colors so lookups actually hit
      if ($urandom_range(99) < 70)
        color = sb.key_color[$urandom_range(rckt_pkg::TABLE_ENTRIES - 1)];
      else color = 24'($urandom());
      alpha = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(1, 255));
      it = pixel_item(color, alpha);
    end
    send_item(it);
  endtask

  initial begin
    int unsigned mode_sel;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table edges, duplicate colors, disabled entry, transparency
    send_item(load_item(0, 24'h000000, 1'b1));
    send_item(load_item(15, 24'hFFFFFF, 1'b1));
    send_item(load_item(3, 24'h123456, 1'b1));
    send_item(load_item(4, 24'h123456, 1'b1));
    send_item(load_item(7, 24'hABCDEF, 1'b0));
    send_item(pixel_item(24'h000000, 8'hFF));
    send_item(pixel_item(24'hFFFFFF, 8'h01));
    send_item(pixel_item(24'h123456, 8'h80));
    send_item(pixel_item(24'hABCDEF, 8'hFF));
    send_item(pixel_item(24'h000000, 8'h00));
    send_item(pixel_item(24'h5A5A5A, 8'h7F));
    send_item(load_item(0, 24'h000000, 1'b0));
    send_item(pixel_item(24'h000000, 8'hFF));
    drain();

    // degenerate sizes: width 0 -> 1, height and grid clamped, zero grid drops all
    write_reg(rckt_pkg::REG_ORIENTATION, 32'(rckt_pkg::ROT_180));
    write_reg(rckt_pkg::REG_IMAGE_WIDTH, 32'd0);
    write_reg(rckt_pkg::REG_IMAGE_HEIGHT, 32'h7FF);
    write_reg(rckt_pkg::REG_ORIGIN_X, 32'd1023);
    write_reg(rckt_pkg::REG_ORIGIN_Y, 32'd0);
    write_reg(rckt_pkg::REG_GRID_WIDTH, 32'h7FF);
    write_reg(rckt_pkg::REG_GRID_HEIGHT, 32'd0);
    send_item(pixel_item(24'hFFFFFF, 8'hFF));
    send_item(pixel_item(24'h123456, 8'hFF));
    drain();
    write_reg(rckt_pkg::REG_GRID_HEIGHT, 32'h7FF);
    send_item(pixel_item(24'hFFFFFF, 8'hFF));
    send_item(pixel_item(24'h123456, 8'hFF));
    send_item(pixel_item(24'hFFFFFF, 8'hFF));
    drain();

    // shrink height under a live row count: rotated x goes negative
    write_reg(rckt_pkg::REG_ORIENTATION, 32'(rckt_pkg::ROT_90));
    write_reg(rckt_pkg::REG_IMAGE_HEIGHT, 32'd1);
    write_reg(rckt_pkg::REG_ORIGIN_X, 32'd0);
    send_item(pixel_item(24'hFFFFFF, 8'hFF));
    send_item(pixel_item(24'hFFFFFF, 8'hFF));
    send_item(pixel_item(24'h123456, 8'hFF));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(rckt_pkg::REG_ORIENTATION, 32'((phase / 2) % 4));
      write_reg(rckt_pkg::REG_IMAGE_WIDTH, pick_image_dim());
      write_reg(rckt_pkg::REG_IMAGE_HEIGHT, pick_image_dim());
      write_reg(rckt_pkg::REG_ORIGIN_X, pick_origin());
      write_reg(rckt_pkg::REG_ORIGIN_Y, pick_origin());
      write_reg(rckt_pkg::REG_GRID_WIDTH, pick_grid_dim());
      write_reg(rckt_pkg::REG_GRID_HEIGHT, pick_grid_dim());
      mode_sel = phase % 4;
      case (mode_sel)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        random_item();
      end
      drain();
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    for (int guard = 0; guard < 10000 && sb.pending() != 0; guard++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0d tile writes never arrived", sb.pending());
    end
    if (sb.errors == 0) begin
      $display("rotated_color_key_tile_mapper_core verification clean");
    end else begin
      $display("rotated_color_key_tile_mapper_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rckt_pkg.sv
hdl/rckt_key_table.sv
hdl/rotated_color_key_tile_mapper_core.sv
test/tb_rotated_color_key_tile_mapper_core.sv
